>>> hdl/tkd_pkg.sv
// ============================================================================
// Terminal key decoder package
// Shared types, byte codes and configuration constants of the key decoder.
// ============================================================================
package tkd_pkg;

    localparam int COORD_BITS_DEFAULT = 10;
    localparam int CURSOR_W           = 10;
    localparam int CFG_DATA_W         = 11;
    localparam int CFG_INDEX_W        = 2;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLS = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SCREEN_ROWS_RESET = 11'd24;
    localparam logic [CFG_DATA_W-1:0] SCREEN_COLS_RESET = 11'd80;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] BRACKET   = 8'h5B;
    localparam logic [7:0] TILDE     = 8'h7E;
    localparam logic [7:0] DIGIT_0   = 8'h30;
    localparam logic [7:0] DIGIT_9   = 8'h39;
    localparam logic [7:0] CHAR_5    = 8'h35;
    localparam logic [7:0] CHAR_6    = 8'h36;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_Q    = 8'h71;
    localparam logic [7:0] CTRL_MASK = 8'h1F;
    localparam logic [7:0] CTRL_Q    = CHAR_Q & CTRL_MASK;

    typedef enum logic [2:0] {
        KIND_PLAIN = 3'd0,
        KIND_LEFT  = 3'd1,
        KIND_RIGHT = 3'd2,
        KIND_UP    = 3'd3,
        KIND_DOWN  = 3'd4,
        KIND_PGUP  = 3'd5,
        KIND_PGDN  = 3'd6
    } t_key_kind;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_key_kind  kind;
        logic [7:0] key_byte;
        logic       quit;
    } t_key_event;

    typedef struct packed {
        t_key_kind           key_kind;
        logic [7:0]          key_byte;
        logic [CURSOR_W-1:0] cursor_row;
        logic [CURSOR_W-1:0] cursor_col;
        logic                quit;
    } t_out_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

>>> hdl/tkd_parser.sv
// ============================================================================
// Key decoder front end
// Tracks escape sequences and turns accepted input beats into key events.
// ============================================================================
module tkd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tkd_pkg::t_in_item i_item,
    output logic              o_ev_valid,
    output tkd_pkg::t_key_event o_event
);
    import tkd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_SEQ1 = 2'd2,
        PH_SEQ2 = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;
    logic       r_halted, n_halted;
    logic [7:0] b;

    assign b = i_item.rx_byte;

    always_comb begin
        n_phase        = r_phase;
        n_first        = r_first;
        n_second       = r_second;
        n_halted       = r_halted;
        o_ev_valid     = 1'b0;
        o_event.kind     = KIND_PLAIN;
        o_event.key_byte = ESC_BYTE;
        o_event.quit     = 1'b0;
        if (i_accept && !r_halted) begin
            if (i_item.command == CMD_TIMEOUT) begin
                if (r_phase != PH_IDLE) begin
                    n_phase    = PH_IDLE;
                    o_ev_valid = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (b == ESC_BYTE) begin
                            n_phase = PH_ESC;
                        end else begin
                            o_ev_valid       = 1'b1;
                            o_event.key_byte = b;
                            if (b == CTRL_Q) begin
                                n_halted     = 1'b1;
                                o_event.quit = 1'b1;
                            end
                        end
                    end
                    PH_ESC: begin
                        n_first = b;
                        n_phase = PH_SEQ1;
                    end
                    PH_SEQ1: begin
                        n_second = b;
                        n_phase  = PH_IDLE;
                        if (r_first == BRACKET && b >= DIGIT_0 && b <= DIGIT_9) begin
                            n_phase = PH_SEQ2;
                        end else begin
                            o_ev_valid = 1'b1;
                            if (r_first == BRACKET) begin
                                unique case (b)
                                    CHAR_A: begin
                                        o_event.kind     = KIND_UP;
                                        o_event.key_byte = 8'h00;
                                    end
                                    CHAR_B: begin
                                        o_event.kind     = KIND_DOWN;
                                        o_event.key_byte = 8'h00;
                                    end
                                    CHAR_C: begin
                                        o_event.kind     = KIND_RIGHT;
                                        o_event.key_byte = 8'h00;
                                    end
                                    CHAR_D: begin
                                        o_event.kind     = KIND_LEFT;
                                        o_event.key_byte = 8'h00;
                                    end
                                    default: begin
                                        o_event.kind = KIND_PLAIN;
                                    end
                                endcase
                            end
                        end
                    end
                    PH_SEQ2: begin
                        n_phase    = PH_IDLE;
                        o_ev_valid = 1'b1;
                        if (b == TILDE && r_second == CHAR_5) begin
                            o_event.kind     = KIND_PGUP;
                            o_event.key_byte = 8'h00;
                        end else if (b == TILDE && r_second == CHAR_6) begin
                            o_event.kind     = KIND_PGDN;
                            o_event.key_byte = 8'h00;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_first  <= 8'h00;
            r_second <= 8'h00;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_halted <= n_halted;
        end
    end

endmodule

>>> hdl/tkd_queue.sv
// ============================================================================
// Key event queue
// Short first-in first-out buffer between the decoder and the cursor unit.
// ============================================================================
module tkd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  tkd_pkg::t_key_event    i_wr_data,
    input  logic                   i_rd,
    output tkd_pkg::t_key_event    o_rd_data,
    output tkd_pkg::t_queue_status o_status
);
    import tkd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_key_event       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr, do_rd;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_FULL);
    assign do_wr          = i_wr && !o_status.full;
    assign do_rd          = i_rd && !o_status.empty;
    assign o_rd_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/tkd_cursor.sv
// ============================================================================
// Cursor unit
// Holds the screen size and the cursor, applies key events and registers
// the result beat.
// ============================================================================
module tkd_cursor #(
    parameter int COORD_BITS = tkd_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tkd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tkd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_ev_valid,
    input  tkd_pkg::t_key_event                 i_event,
    output logic                                o_ev_take,
    input  logic                                i_pop,
    output logic                                o_empty,
    output tkd_pkg::t_out_item                  o_item
);
    import tkd_pkg::*;

    localparam int SW    = (COORD_BITS + 1 > CFG_DATA_W) ? COORD_BITS + 1 : CFG_DATA_W;
    localparam int EXT_W = COORD_BITS + CURSOR_W;

    logic [CFG_DATA_W-1:0] r_rows, r_cols;
    logic [COORD_BITS-1:0] r_row, r_col, n_row, n_col;
    logic [COORD_BITS-1:0] last_row, last_col;
    logic [EXT_W-1:0]      row_ext, col_ext;
    logic                  r_out_valid;
    t_out_item             r_out;

    function automatic logic [COORD_BITS-1:0] last_of(input logic [CFG_DATA_W-1:0] v);
        logic [SW-1:0] ext;
        logic [SW-1:0] lim;
        logic [SW-1:0] dec;
        ext = SW'(v);
        lim = SW'(1) << COORD_BITS;
        dec = ext - SW'(1);
        if (v == '0) begin
            last_of = '0;
        end else if (ext > lim) begin
            last_of = '1;
        end else begin
            last_of = dec[COORD_BITS-1:0];
        end
    endfunction

    assign last_row  = last_of(r_rows);
    assign last_col  = last_of(r_cols);
    assign o_ev_take = i_ev_valid && (!r_out_valid || i_pop);
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        unique case (i_event.kind)
            KIND_UP: begin
                if (r_row != '0) n_row = r_row - COORD_BITS'(1);
            end
            KIND_LEFT: begin
                if (r_col != '0) n_col = r_col - COORD_BITS'(1);
            end
            KIND_DOWN: begin
                if (r_row < last_row) n_row = r_row + COORD_BITS'(1);
            end
            KIND_RIGHT: begin
                if (r_col < last_col) n_col = r_col + COORD_BITS'(1);
            end
            KIND_PGUP: begin
                n_row = '0;
            end
            KIND_PGDN: begin
                n_row = last_row;
            end
            default: begin
                n_row = r_row;
            end
        endcase
    end

    assign row_ext = {{CURSOR_W{1'b0}}, n_row};
    assign col_ext = {{CURSOR_W{1'b0}}, n_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= SCREEN_ROWS_RESET;
            r_cols      <= SCREEN_COLS_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_SCREEN_ROWS) begin
                r_rows <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_SCREEN_COLS) begin
                r_cols <= i_cfg_data;
            end
            if (o_ev_take) begin
                r_row       <= n_row;
                r_col       <= n_col;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_take) begin
            r_out.key_kind   <= i_event.kind;
            r_out.key_byte   <= i_event.key_byte;
            r_out.cursor_row <= row_ext[CURSOR_W-1:0];
            r_out.cursor_col <= col_ext[CURSOR_W-1:0];
            r_out.quit       <= i_event.quit;
        end
    end

endmodule

>>> hdl/terminal_key_decoder_cursor.sv
// ============================================================================
// Terminal key decoder with cursor
// Decodes terminal bytes and timeouts into keys and tracks a clamped cursor.
// ============================================================================
// An input beat is taken in every cycle in which the key event queue has
// room; any result beat passes the event queue and then the cursor unit's
// output register. Both sides run at one beat per cycle while the event
// queue has room and results are popped; the two-entry event queue
// between decoder and cursor unit lets input continue while a result beat
// waits to be popped. Configuration writes are taken in every cycle and
// there is no clearing pass after reset.
module terminal_key_decoder_cursor #(
    parameter int COORD_BITS = tkd_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  tkd_pkg::t_in_item               i_item,
    output logic                            empty,
    input  logic                            pop,
    output tkd_pkg::t_out_item              o_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tkd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tkd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tkd_pkg::*;

    t_queue_status q_status;
    t_key_event    fe_event, q_event;
    logic          fe_valid, ev_take, accept;

    assign o_cfg_ready = 1'b1;
    assign full        = q_status.full;
    assign accept      = push && !q_status.full;

    tkd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_ev_valid (fe_valid),
        .o_event    (fe_event)
    );

    tkd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (fe_valid),
        .i_wr_data (fe_event),
        .i_rd      (ev_take),
        .o_rd_data (q_event),
        .o_status  (q_status)
    );

    tkd_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ev_valid  (!q_status.empty),
        .i_event     (q_event),
        .o_ev_take   (ev_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_item)
    );

endmodule

>>> hdl/tkd_checker.sv
// ============================================================================
// Key decoder port checker
// Concurrent checks on the result beats seen at the top level's ports.
// ============================================================================
module tkd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input tkd_pkg::t_out_item o_item
);
    import tkd_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        (!i_rst_n) |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("waiting result beat changed before pop");

    a_quit_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_item.quit || (o_item.key_kind == KIND_PLAIN
                                    && o_item.key_byte == CTRL_Q)))
        |-> (o_item.quit && o_item.key_kind == KIND_PLAIN
             && o_item.key_byte == CTRL_Q))
        else $error("quit flag and Ctrl-Q byte disagree");

    a_nav_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.key_kind != KIND_PLAIN) |-> (o_item.key_byte == 8'h00))
        else $error("navigation key beat carries a byte");

    a_pgup_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.key_kind == KIND_PGUP) |-> (o_item.cursor_row == '0))
        else $error("page up beat with nonzero row");

endmodule

bind terminal_key_decoder_cursor tkd_checker u_tkd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);
